// ===== design/wstq_pkg.sv =====
// Shared types and constants of the work-stealing task queue.
package wstq_pkg;

    localparam int WORKERS_DEF     = 8;
    localparam int PRIORITIES_DEF  = 4;
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int TASK_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_STEAL_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WORKERS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVELS     = 2'd2;

    localparam logic [1:0] KIND_PRIV  = 2'd0;
    localparam logic [1:0] KIND_PUB   = 2'd1;
    localparam logic [1:0] KIND_STEAL = 2'd2;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_SCAN,
        ST_POP_SRCH,
        ST_META_RD,
        ST_META_EVAL,
        ST_STORE_EVAL
    } t_state;

endpackage

// ===== design/wstq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wstq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/wstq_mod.sv =====
// Bit-serial remainder unit: one dividend bit per cycle.
module wstq_mod #(
    parameter int DVD_W = 16,
    parameter int DIV_W = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_rem
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_dvd;
    logic [DIV_W-1:0] r_div;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[DVD_W-1]};
        if (trial >= {1'b0, r_div}) begin
            n_rem = trial - {1'b0, r_div};
        end else begin
            n_rem = trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= n_rem[DIV_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

// ===== design/work_stealing_task_queue_unit.sv =====
// Work-stealing task queue: per-worker, per-priority private and public FIFOs of task words.
// A push first passes through the remainder unit, then for a restricted push through the
// affinity scan, which examines the workers one by one, then through queue bookkeeping; a
// pop examines queues one by one in the search sequencer (at most 1 + workers per level),
// then accesses the memories when a task is found. A push whose affinity names no active
// worker, or a pop by an inactive worker, finishes at once. The result word appears on the
// output ports for exactly one cycle with o_strobe, in the first cycle with busy low after
// the word was accepted, and must be taken then: there is no back-pressure. The next start
// may be given in that same cycle.
module work_stealing_task_queue_unit #(
    parameter int WORKERS     = wstq_pkg::WORKERS_DEF,
    parameter int PRIORITIES  = wstq_pkg::PRIORITIES_DEF,
    parameter int QUEUE_DEPTH = wstq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_cfg_we,
    input  logic [wstq_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wstq_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_op,
    input  logic [15:0]                     i_task_id,
    input  logic [1:0]                      i_task_priority,
    input  logic [7:0]                      i_allowed_workers,
    input  logic [2:0]                      i_requester,
    output logic                            o_strobe,
    output logic                            o_success,
    output logic [15:0]                     o_task_out,
    output logic [2:0]                      o_target_worker,
    output logic [1:0]                      o_source_kind,
    output logic [1:0]                      o_found_priority
);
    localparam int WW  = $clog2(WORKERS);
    localparam int CW  = $clog2(WORKERS + 1);
    localparam int PW  = (PRIORITIES > 1) ? $clog2(PRIORITIES) : 1;
    localparam int LCW = $clog2(PRIORITIES + 1);
    localparam int NQ  = WORKERS * PRIORITIES * 2;
    localparam int QW  = $clog2(NQ);
    localparam int HW  = $clog2(QUEUE_DEPTH);
    localparam int FW  = $clog2(QUEUE_DEPTH + 1);
    localparam int MW  = HW + FW;
    localparam int SD  = NQ * QUEUE_DEPTH;
    localparam int AW  = $clog2(SD);

    function automatic logic [QW-1:0] qidx(input logic [WW-1:0] w, input logic [PW-1:0] p,
                                           input logic k);
        qidx = QW'((32'(w) * PRIORITIES + 32'(p)) * 2 + 32'(k));
    endfunction

    wstq_pkg::t_state r_state, n_state;

    logic              r_steal_mode;
    logic [3:0]        r_workers;
    logic [2:0]        r_levels;
    logic [2:0]        r_rotor;

    logic              r_is_pop;
    logic [15:0]       r_id;
    logic [PW-1:0]     r_lvl;
    logic [1:0]        r_kind;
    logic [WW-1:0]     r_w;
    logic [WW-1:0]     r_req;
    logic [WW-1:0]     r_wk;
    logic [WW-1:0]     r_cnt;
    logic              r_unres;
    logic [WORKERS-1:0] r_mask;
    logic [WW-1:0]     r_c;
    logic [QW-1:0]     r_q;
    logic              r_mvld;
    logic [NQ-1:0]     r_meta_vld;
    logic [NQ-1:0]     r_nonempty;

    logic              r_strobe;
    logic              r_success;
    logic [15:0]       r_task_out;
    logic [2:0]        r_target;
    logic [1:0]        r_src;
    logic [1:0]        r_fprio;

    logic [CW-1:0]     wc;
    logic [LCW-1:0]    lv;
    logic [WORKERS-1:0] all_mask;
    logic [WORKERS-1:0] aff_m;
    logic [31:0]       aff32;
    logic              unres_c;
    logic              acc;
    logic              req_bad;
    logic [PW-1:0]     push_p;

    logic              mod_start;
    logic              mod_done;
    logic [15:0]       mod_dvd;
    logic [CW-1:0]     mod_rem;

    logic [QW-1:0]     cand_q;
    logic [WW-1:0]     cand_w;
    logic              hit;
    logic              exhaust;
    logic [1:0]        n_kind;
    logic [PW-1:0]     n_lvl;
    logic [WW-1:0]     n_wk;
    logic [WW-1:0]     n_cnt;
    logic [WW-1:0]     wk_first;
    logic [WW-1:0]     wk_next;
    logic              more_steal;
    logic              more_lvl;
    logic              has_steal;

    logic              meta_re;
    logic              meta_we;
    logic [MW-1:0]     meta_wdata;
    logic [MW-1:0]     meta_rdata;
    logic [HW-1:0]     head_e;
    logic [FW-1:0]     fill_e;
    logic [HW-1:0]     head_nx;
    logic [FW:0]       slot_sum;
    logic [HW-1:0]     slot;
    logic              full;
    logic              store_we;
    logic              store_re;
    logic [AW-1:0]     store_waddr;
    logic [AW-1:0]     store_raddr;
    logic [15:0]       store_rdata;
    logic              fin_fail;
    logic              fin_push;
    logic              fin_pop;

    always_comb begin
        if (r_workers == 4'd0) begin
            wc = CW'(1);
        end else if (32'(r_workers) > WORKERS) begin
            wc = CW'(WORKERS);
        end else begin
            wc = CW'(r_workers);
        end
        if (r_levels == 3'd0) begin
            lv = LCW'(1);
        end else if (32'(r_levels) > PRIORITIES) begin
            lv = LCW'(PRIORITIES);
        end else begin
            lv = LCW'(r_levels);
        end
    end

    always_comb begin
        for (int i = 0; i < WORKERS; i++) begin
            all_mask[i] = (i < 32'(wc));
        end
        aff32   = 32'(i_allowed_workers);
        aff_m   = aff32[WORKERS-1:0] & all_mask;
        unres_c = (i_allowed_workers == 8'd0) || (aff_m == all_mask);
        acc     = start && !busy;
        req_bad = (32'(i_requester) >= 32'(wc));
        if (32'(i_task_priority) > PRIORITIES - 1) begin
            push_p = PW'(PRIORITIES - 1);
        end else begin
            push_p = PW'(i_task_priority);
        end
        mod_dvd = unres_c ? i_task_id : 16'(r_rotor);
    end

    // search sequencer: candidate queue and its successor
    always_comb begin
        cand_w   = (r_kind == wstq_pkg::KIND_STEAL) ? r_wk : r_req;
        cand_q   = qidx(cand_w, r_lvl, r_kind != wstq_pkg::KIND_PRIV);
        hit      = r_nonempty[cand_q];
        wk_first = (CW'(r_req) + CW'(1) == wc) ? '0 : WW'(CW'(r_req) + CW'(1));
        wk_next  = (CW'(r_wk) + CW'(1) == wc) ? '0 : WW'(CW'(r_wk) + CW'(1));
        more_steal = ((CW + 1)'(r_cnt) + (CW + 1)'(2) < (CW + 1)'(wc));
        more_lvl   = ((LCW + 1)'(r_lvl) + (LCW + 1)'(1) < (LCW + 1)'(lv));
        has_steal  = (wc >= CW'(2));
        n_kind  = r_kind;
        n_lvl   = r_lvl;
        n_wk    = r_wk;
        n_cnt   = r_cnt;
        exhaust = 1'b0;
        if (!r_steal_mode) begin
            unique case (r_kind)
                wstq_pkg::KIND_PRIV: begin
                    n_kind = wstq_pkg::KIND_PUB;
                end
                wstq_pkg::KIND_PUB: begin
                    if (has_steal) begin
                        n_kind = wstq_pkg::KIND_STEAL;
                        n_wk   = wk_first;
                        n_cnt  = '0;
                    end else if (more_lvl) begin
                        n_kind = wstq_pkg::KIND_PRIV;
                        n_lvl  = r_lvl + 1'b1;
                    end else begin
                        exhaust = 1'b1;
                    end
                end
                default: begin
                    if (more_steal) begin
                        n_wk  = wk_next;
                        n_cnt = r_cnt + 1'b1;
                    end else if (more_lvl) begin
                        n_kind = wstq_pkg::KIND_PRIV;
                        n_lvl  = r_lvl + 1'b1;
                    end else begin
                        exhaust = 1'b1;
                    end
                end
            endcase
        end else begin
            unique case (r_kind)
                wstq_pkg::KIND_PRIV: begin
                    if (more_lvl) begin
                        n_lvl = r_lvl + 1'b1;
                    end else begin
                        n_kind = wstq_pkg::KIND_PUB;
                        n_lvl  = '0;
                    end
                end
                wstq_pkg::KIND_PUB: begin
                    if (more_lvl) begin
                        n_lvl = r_lvl + 1'b1;
                    end else if (has_steal) begin
                        n_kind = wstq_pkg::KIND_STEAL;
                        n_lvl  = '0;
                        n_wk   = wk_first;
                        n_cnt  = '0;
                    end else begin
                        exhaust = 1'b1;
                    end
                end
                default: begin
                    if (more_steal) begin
                        n_wk  = wk_next;
                        n_cnt = r_cnt + 1'b1;
                    end else if (more_lvl) begin
                        n_lvl = r_lvl + 1'b1;
                        n_wk  = wk_first;
                        n_cnt = '0;
                    end else begin
                        exhaust = 1'b1;
                    end
                end
            endcase
        end
    end

    // queue bookkeeping
    always_comb begin
        head_e   = r_mvld ? meta_rdata[MW-1:FW] : '0;
        fill_e   = r_mvld ? meta_rdata[FW-1:0] : '0;
        full     = (32'(fill_e) >= QUEUE_DEPTH);
        slot_sum = (FW + 1)'(head_e) + (FW + 1)'(fill_e);
        if (32'(slot_sum) >= QUEUE_DEPTH) begin
            slot = HW'(32'(slot_sum) - QUEUE_DEPTH);
        end else begin
            slot = HW'(slot_sum);
        end
        head_nx     = (32'(head_e) + 1 == QUEUE_DEPTH) ? '0 : head_e + 1'b1;
        store_waddr = AW'(32'(r_q) * QUEUE_DEPTH + 32'(slot));
        store_raddr = AW'(32'(r_q) * QUEUE_DEPTH + 32'(head_e));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wstq_pkg::ST_IDLE: begin
                if (acc) begin
                    if (i_op == wstq_pkg::OP_POP) begin
                        n_state = req_bad ? wstq_pkg::ST_IDLE : wstq_pkg::ST_POP_SRCH;
                    end else begin
                        n_state = (!unres_c && aff_m == '0) ? wstq_pkg::ST_IDLE
                                                             : wstq_pkg::ST_MOD;
                    end
                end
            end
            wstq_pkg::ST_MOD: begin
                if (mod_done) begin
                    n_state = r_unres ? wstq_pkg::ST_META_RD : wstq_pkg::ST_SCAN;
                end
            end
            wstq_pkg::ST_SCAN: begin
                if (r_mask[r_c]) begin
                    n_state = wstq_pkg::ST_META_RD;
                end
            end
            wstq_pkg::ST_POP_SRCH: begin
                if (hit) begin
                    n_state = wstq_pkg::ST_META_RD;
                end else if (exhaust) begin
                    n_state = wstq_pkg::ST_IDLE;
                end
            end
            wstq_pkg::ST_META_RD: begin
                n_state = wstq_pkg::ST_META_EVAL;
            end
            wstq_pkg::ST_META_EVAL: begin
                n_state = r_is_pop ? wstq_pkg::ST_STORE_EVAL : wstq_pkg::ST_IDLE;
            end
            wstq_pkg::ST_STORE_EVAL: begin
                n_state = wstq_pkg::ST_IDLE;
            end
            default: begin
                n_state = wstq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        mod_start  = 1'b0;
        meta_re    = 1'b0;
        meta_we    = 1'b0;
        meta_wdata = {head_e, fill_e};
        store_we   = 1'b0;
        store_re   = 1'b0;
        fin_fail   = 1'b0;
        fin_push   = 1'b0;
        fin_pop    = 1'b0;
        unique case (r_state)
            wstq_pkg::ST_IDLE: begin
                if (acc) begin
                    if (i_op == wstq_pkg::OP_POP) begin
                        fin_fail = req_bad;
                    end else if (!unres_c && aff_m == '0) begin
                        fin_fail = 1'b1;
                    end else begin
                        mod_start = 1'b1;
                    end
                end
            end
            wstq_pkg::ST_POP_SRCH: begin
                fin_fail = !hit && exhaust;
            end
            wstq_pkg::ST_META_RD: begin
                meta_re = 1'b1;
            end
            wstq_pkg::ST_META_EVAL: begin
                if (r_is_pop) begin
                    store_re   = 1'b1;
                    meta_we    = 1'b1;
                    meta_wdata = {head_nx, fill_e - 1'b1};
                end else begin
                    fin_push = 1'b1;
                    if (!full) begin
                        store_we   = 1'b1;
                        meta_we    = 1'b1;
                        meta_wdata = {head_e, fill_e + 1'b1};
                    end
                end
            end
            wstq_pkg::ST_STORE_EVAL: begin
                fin_pop = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= wstq_pkg::ST_IDLE;
            r_steal_mode <= 1'b0;
            r_workers    <= 4'd8;
            r_levels     <= 3'd4;
            r_rotor      <= '0;
            r_meta_vld   <= '0;
            r_nonempty   <= '0;
            r_strobe     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= fin_fail || fin_push || fin_pop;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    wstq_pkg::REG_STEAL_MODE: r_steal_mode <= i_cfg_data[0];
                    wstq_pkg::REG_WORKERS:    r_workers    <= i_cfg_data[3:0];
                    wstq_pkg::REG_LEVELS:     r_levels     <= i_cfg_data[2:0];
                    default: begin
                    end
                endcase
            end
            if (mod_start && !unres_c) begin
                r_rotor <= r_rotor + 1'b1;
            end
            if (meta_we) begin
                r_meta_vld[r_q] <= 1'b1;
                r_nonempty[r_q] <= r_is_pop ? (fill_e != FW'(1)) : 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == wstq_pkg::ST_IDLE && acc) begin
            r_is_pop <= (i_op == wstq_pkg::OP_POP);
            r_id     <= i_task_id;
            r_lvl    <= (i_op == wstq_pkg::OP_POP) ? '0 : push_p;
            r_kind   <= wstq_pkg::KIND_PRIV;
            r_req    <= WW'(i_requester);
            r_unres  <= unres_c;
            r_mask   <= aff_m;
        end
        if (r_state == wstq_pkg::ST_MOD && mod_done) begin
            r_w   <= WW'(mod_rem);
            r_c   <= WW'(mod_rem);
            r_q   <= qidx(WW'(mod_rem), r_lvl, 1'b1);
            r_kind <= r_unres ? wstq_pkg::KIND_PUB : wstq_pkg::KIND_PRIV;
        end
        if (r_state == wstq_pkg::ST_SCAN) begin
            if (r_mask[r_c]) begin
                r_w <= r_c;
                r_q <= qidx(r_c, r_lvl, 1'b0);
            end else begin
                r_c <= (CW'(r_c) + CW'(1) == wc) ? '0 : WW'(CW'(r_c) + CW'(1));
            end
        end
        if (r_state == wstq_pkg::ST_POP_SRCH) begin
            if (hit) begin
                r_w <= cand_w;
                r_q <= cand_q;
            end else begin
                r_kind <= n_kind;
                r_lvl  <= n_lvl;
                r_wk   <= n_wk;
                r_cnt  <= n_cnt;
            end
        end
        if (meta_re) begin
            r_mvld <= r_meta_vld[r_q];
        end
        if (fin_fail) begin
            r_success  <= 1'b0;
            r_task_out <= '0;
            r_target   <= '0;
            r_src      <= '0;
            r_fprio    <= '0;
        end else if (fin_push) begin
            r_success  <= !full;
            r_task_out <= '0;
            r_target   <= 3'(r_w);
            r_src      <= r_kind;
            r_fprio    <= 2'(r_lvl);
        end else if (fin_pop) begin
            r_success  <= 1'b1;
            r_task_out <= store_rdata;
            r_target   <= 3'(r_w);
            r_src      <= r_kind;
            r_fprio    <= 2'(r_lvl);
        end
    end

    wstq_mod #(
        .DVD_W (16),
        .DIV_W (CW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (mod_dvd),
        .i_divisor  (wc),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    wstq_ram #(
        .WIDTH (MW),
        .DEPTH (NQ)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (r_q),
        .i_wdata (meta_wdata),
        .i_re    (meta_re),
        .i_raddr (r_q),
        .o_rdata (meta_rdata)
    );

    wstq_ram #(
        .WIDTH (16),
        .DEPTH (SD)
    ) u_store_ram (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (store_waddr),
        .i_wdata (r_id),
        .i_re    (store_re),
        .i_raddr (store_raddr),
        .o_rdata (store_rdata)
    );

    assign busy             = (r_state != wstq_pkg::ST_IDLE);
    assign o_strobe         = r_strobe;
    assign o_success        = r_success;
    assign o_task_out       = r_task_out;
    assign o_target_worker  = r_target;
    assign o_source_kind    = r_src;
    assign o_found_priority = r_fprio;

`ifndef SYNTH
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result shown while busy");
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_strobe))
        else $error("accepted word neither worked on nor answered");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_success) |-> (o_task_out == 16'd0))
        else $error("failed result carries a task");
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_source_kind <= wstq_pkg::KIND_STEAL))
        else $error("illegal source kind");
`endif
endmodule

// ===== sim/tb.sv =====
// Self-checking testbench of the work-stealing task queue unit.
module tb;
    localparam int NW = wstq_pkg::WORKERS_DEF;
    localparam int NP = wstq_pkg::PRIORITIES_DEF;
    localparam int QD = wstq_pkg::QUEUE_DEPTH_DEF;
    localparam int NQ = NW * NP * 2;
    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        logic        success;
        logic [15:0] task_out;
        logic [2:0]  target;
        logic [1:0]  kind;
        logic [1:0]  prio;
    } t_word;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            start;
    logic                            busy;
    logic                            i_cfg_we;
    logic [wstq_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [wstq_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                            i_op;
    logic [15:0]                     i_task_id;
    logic [1:0]                      i_task_priority;
    logic [7:0]                      i_allowed_workers;
    logic [2:0]                      i_requester;
    logic                            o_strobe;
    logic                            o_success;
    logic [15:0]                     o_task_out;
    logic [2:0]                      o_target_worker;
    logic [1:0]                      o_source_kind;
    logic [1:0]                      o_found_priority;

    work_stealing_task_queue_unit dut (.*);

    logic [15:0] fifo_mem [NQ][QD];
    int          fifo_head [NQ];
    int          fifo_fill [NQ];
    logic [2:0]  rotor;
    logic        mode_reg;
    logic [3:0]  workers_reg;
    logic [2:0]  levels_reg;

    t_word pending_words [$];
    int    errors;
    int    stall_cycles;
    int    idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int queue_no(int w, int p, int kind);
        return (w * NP + p) * 2 + kind;
    endfunction

    function automatic bit take(int q, output logic [15:0] id);
        if (fifo_fill[q] == 0) return 1'b0;
        id = fifo_mem[q][fifo_head[q]];
        fifo_head[q] = (fifo_head[q] + 1) % QD;
        fifo_fill[q]--;
        return 1'b1;
    endfunction

    function automatic int steal_at(int r, int p, int wc, output logic [15:0] id);
        int w;
        w = (r + 1) % wc;
        for (int k = 0; k + 1 < wc; k++) begin
            if (take(queue_no(w, p, 1), id)) return w;
            w = (w + 1) % wc;
        end
        return -1;
    endfunction

    function automatic t_word dispatch(logic op, logic [15:0] id, logic [1:0] pr,
                                       logic [7:0] aff, logic [2:0] rq);
        t_word       res;
        int          wc, lv, w, kind, fp, q, s;
        logic [7:0]  all, m;
        logic [15:0] got;
        res = '0;
        wc = (workers_reg < 1) ? 1 : (workers_reg > NW) ? NW : workers_reg;
        lv = (levels_reg < 1) ? 1 : (levels_reg > NP) ? NP : levels_reg;
        all = 8'((1 << wc) - 1);
        got = '0;
        if (op == wstq_pkg::OP_PUSH) begin
            m = aff & all;
            if (aff == 0 || m == all) begin
                w = id % wc;
                kind = wstq_pkg::KIND_PUB;
            end else begin
                if (m == 0) return res;
                s = rotor % wc;
                rotor = rotor + 3'd1;
                w = s;
                for (int k = 0; k < wc; k++) begin
                    if (m[(s + k) % wc]) begin
                        w = (s + k) % wc;
                        break;
                    end
                end
                kind = wstq_pkg::KIND_PRIV;
            end
            q = queue_no(w, pr, kind);
            if (fifo_fill[q] < QD) begin
                fifo_mem[q][(fifo_head[q] + fifo_fill[q]) % QD] = id;
                fifo_fill[q]++;
                res.success = 1'b1;
            end
            res.target = 3'(w);
            res.kind = 2'(kind);
            res.prio = pr;
            return res;
        end
        if (rq >= wc) return res;
        w = -1;
        kind = 0;
        fp = 0;
        if (mode_reg == 1'b0) begin
            for (int p = 0; p < lv && w < 0; p++) begin
                if (take(queue_no(rq, p, 0), got)) begin
                    w = rq;
                    kind = wstq_pkg::KIND_PRIV;
                end else if (take(queue_no(rq, p, 1), got)) begin
                    w = rq;
                    kind = wstq_pkg::KIND_PUB;
                end else begin
                    w = steal_at(rq, p, wc, got);
                    kind = wstq_pkg::KIND_STEAL;
                end
                fp = p;
            end
        end else begin
            for (int p = 0; p < lv && w < 0; p++)
                if (take(queue_no(rq, p, 0), got)) begin
                    w = rq;
                    kind = wstq_pkg::KIND_PRIV;
                    fp = p;
                end
            for (int p = 0; p < lv && w < 0; p++)
                if (take(queue_no(rq, p, 1), got)) begin
                    w = rq;
                    kind = wstq_pkg::KIND_PUB;
                    fp = p;
                end
            for (int p = 0; p < lv && w < 0; p++) begin
                w = steal_at(rq, p, wc, got);
                kind = wstq_pkg::KIND_STEAL;
                fp = p;
            end
        end
        if (w < 0) return res;
        res.success = 1'b1;
        res.task_out = got;
        res.target = 3'(w);
        res.kind = 2'(kind);
        res.prio = 2'(fp);
        return res;
    endfunction

    // send one word; start stays high so a following word can go back to back
    task automatic send_word(logic op, logic [15:0] id, logic [1:0] pr,
                             logic [7:0] aff, logic [2:0] rq);
        int gap;
        gap = 0;
        if ($urandom_range(99) < idle_pct) gap = $urandom_range(1, 6);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_op <= op;
        i_task_id <= id;
        i_task_priority <= pr;
        i_allowed_workers <= aff;
        i_requester <= rq;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_words.push_back(dispatch(op, id, pr, aff, rq));
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [wstq_pkg::CFG_IDX_W-1:0] idx,
                             logic [wstq_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            wstq_pkg::REG_STEAL_MODE: mode_reg = data[0];
            wstq_pkg::REG_WORKERS:    workers_reg = data;
            wstq_pkg::REG_LEVELS:     levels_reg = data[2:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [3:0] mode, logic [3:0] wk, logic [3:0] lv);
        drain();
        write_reg(wstq_pkg::REG_STEAL_MODE, mode);
        write_reg(wstq_pkg::REG_WORKERS, wk);
        write_reg(wstq_pkg::REG_LEVELS, lv);
    endtask

    task automatic test_directed();
        idle_pct = 0;
        set_config(4'd0, 4'd8, 4'd4);
        send_word(wstq_pkg::OP_POP, 16'h0000, 2'd0, 8'h00, 3'd0);
        send_word(wstq_pkg::OP_PUSH, 16'hFFFF, 2'd3, 8'h00, 3'd7);
        send_word(wstq_pkg::OP_PUSH, 16'h0001, 2'd0, 8'hFF, 3'd0);
        send_word(wstq_pkg::OP_PUSH, 16'h1234, 2'd1, 8'h80, 3'd0);
        send_word(wstq_pkg::OP_PUSH, 16'hA5A5, 2'd2, 8'h06, 3'd0);
        send_word(wstq_pkg::OP_POP, 16'h0000, 2'd0, 8'h00, 3'd1);
        send_word(wstq_pkg::OP_POP, 16'h0000, 2'd0, 8'h00, 3'd7);
        send_word(wstq_pkg::OP_POP, 16'h0000, 2'd0, 8'h00, 3'd7);
        send_word(wstq_pkg::OP_POP, 16'h0000, 2'd0, 8'h00, 3'd2);
        send_word(wstq_pkg::OP_POP, 16'h0000, 2'd0, 8'h00, 3'd3);
        set_config(4'd1, 4'd4, 4'd1);
        send_word(wstq_pkg::OP_PUSH, 16'h0010, 2'd3, 8'hF0, 3'd0);
        send_word(wstq_pkg::OP_PUSH, 16'h0020, 2'd3, 8'hFF, 3'd0);
        send_word(wstq_pkg::OP_POP, 16'h0000, 2'd0, 8'h00, 3'd5);
        send_word(wstq_pkg::OP_POP, 16'h0000, 2'd0, 8'h00, 3'd0);
        send_word(wstq_pkg::OP_PUSH, 16'h0030, 2'd0, 8'h02, 3'd0);
        send_word(wstq_pkg::OP_POP, 16'h0000, 2'd0, 8'h00, 3'd1);
        set_config(4'd0, 4'd0, 4'd7);
        for (int k = 0; k < 17; k++)
            send_word(wstq_pkg::OP_PUSH, 16'(k * 3), 2'd1, 8'h00, 3'd0);
        send_word(wstq_pkg::OP_POP, 16'h0000, 2'd0, 8'h00, 3'd0);
    endtask

    task automatic test_random_phase(int count);
        logic [7:0] aff;
        int         sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(9);
            case (sel)
                0, 1:    aff = 8'h00;
                2:       aff = 8'hFF;
                3, 4:    aff = 8'(1 << $urandom_range(7));
                default: aff = 8'($urandom);
            endcase
            if ($urandom_range(99) < 55)
                send_word(wstq_pkg::OP_PUSH, 16'($urandom), 2'($urandom), aff, 3'($urandom));
            else
                send_word(wstq_pkg::OP_POP, 16'($urandom), 2'($urandom), aff, 3'($urandom));
        end
    endtask

    task automatic test_random();
        int pcts [3] = '{16, 48, 0};
        foreach (pcts[i]) begin
            idle_pct = pcts[i];
            set_config(4'd1, 4'd1, 4'd4);
            test_random_phase(50);
            set_config(4'($urandom), 4'($urandom_range(1, 15)), 4'($urandom));
            test_random_phase(50);
            set_config(4'd0, 4'd8, 4'd0);
            test_random_phase(50);
        end
    endtask

    always @(posedge i_clk) begin
        t_word got, want;
        if (i_rst_n && o_strobe) begin
            got = '{o_success, o_task_out, o_target_worker, o_source_kind, o_found_priority};
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word %h", $time, got);
                errors++;
            end else begin
                want = pending_words.pop_front();
                if (got.success !== want.success) begin
                    $display("%0t: success exp %h got %h", $time, want.success, got.success);
                    errors++;
                end
                if (got.task_out !== want.task_out) begin
                    $display("%0t: task_out exp %h got %h", $time, want.task_out, got.task_out);
                    errors++;
                end
                if (got.target !== want.target) begin
                    $display("%0t: target exp %h got %h", $time, want.target, got.target);
                    errors++;
                end
                if (got.kind !== want.kind) begin
                    $display("%0t: kind exp %h got %h", $time, want.kind, got.kind);
                    errors++;
                end
                if (got.prio !== want.prio) begin
                    $display("%0t: priority exp %h got %h", $time, want.prio, got.prio);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || i_cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        errors = 0;
        stall_cycles = 0;
        idle_pct = 0;
        for (int q = 0; q < NQ; q++) begin
            fifo_head[q] = 0;
            fifo_fill[q] = 0;
        end
        rotor = '0;
        mode_reg = 1'b0;
        workers_reg = 4'd8;
        levels_reg = 3'd4;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_op = wstq_pkg::OP_PUSH;
        i_task_id = '0;
        i_task_priority = '0;
        i_allowed_workers = '0;
        i_requester = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        drain();
        repeat (60) @(posedge i_clk);
        if (errors == 0 && pending_words.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
